FILE: hw/rtl/arm_pkg.sv
// shared constants, angle table and stage types for the axis rotation matrix block
package arm_pkg;

    localparam int TABLE_LEN = 24;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ONE_Q14 = 16384;

    // phase scale factors: one turn is 2^32 phase units
    localparam logic [34:0] RAD_MUL = 35'd5468522205;
    localparam logic [34:0] DEG_MUL = 35'd24433591728;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef enum logic [1:0] {
        KIND_X = 2'd0,
        KIND_Y = 2'd1,
        KIND_Z = 2'd2
    } t_kind;

    // one word in flight through the rotation stages
    typedef struct packed {
        logic               vld;
        logic [1:0]         kind;
        logic [1:0]         quad;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_cord;

endpackage

FILE: hw/rtl/arm_phase.sv
// angle to phase conversion and quadrant reduction, three register stages
module arm_phase (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_angle,
    input  logic               i_radians,
    output arm_pkg::t_cord     o_st
);
    import arm_pkg::*;

    logic               r_vld1, r_vld2;
    logic [1:0]         r_kind1, r_kind2;
    logic [47:0]        r_prod;
    logic [31:0]        r_phase;
    t_cord              r_st;

    logic signed [35:0] mulc;
    logic signed [47:0] n_full;
    logic [47:0]        n_round;
    logic [31:0]        n_qsum;
    t_cord              n_st;

    always_comb begin
        mulc    = $signed({1'b0, (i_radians ? RAD_MUL : DEG_MUL)});
        // only the low 48 bits of the product reach the phase
        n_full  = i_angle * mulc;
        n_round = r_prod + 48'h8000;
        // quadrant nearest to the phase, residual kept signed within an eighth turn
        n_qsum  = r_phase + 32'h2000_0000;
        n_st.vld  = r_vld2;
        n_st.kind = r_kind2;
        n_st.quad = n_qsum[31:30];
        n_st.x    = CORDIC_GAIN;
        n_st.y    = 32'sd0;
        n_st.z    = $signed(r_phase - {n_qsum[31:30], 30'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1   <= 1'b0;
            r_vld2   <= 1'b0;
            r_st.vld <= 1'b0;
        end else if (i_en) begin
            r_vld1  <= i_vld;
            r_kind1 <= i_kind;
            r_prod  <= n_full;
            r_vld2  <= r_vld1;
            r_kind2 <= r_kind1;
            r_phase <= n_round[47:16];
            r_st    <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

FILE: hw/rtl/arm_cordic_stage.sv
// one rotation-mode cordic step with its own register
module arm_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  arm_pkg::t_cord i_st,
    output arm_pkg::t_cord o_st
);
    import arm_pkg::*;

    t_cord              r_st, n_st;
    logic signed [31:0] dx, dy;

    always_comb begin
        dx   = i_st.y >>> IDX;
        dy   = i_st.x >>> IDX;
        n_st = i_st;
        if (!i_st.z[31]) begin
            n_st.x = i_st.x - dx;
            n_st.y = i_st.y + dy;
            n_st.z = i_st.z - ATAN_TURNS[IDX];
        end else begin
            n_st.x = i_st.x + dx;
            n_st.y = i_st.y - dy;
            n_st.z = i_st.z + ATAN_TURNS[IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

FILE: hw/rtl/arm_post.sv
// quadrant unfold, then rounding and saturation to q1.14
module arm_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  arm_pkg::t_cord     i_st,
    output logic               o_vld,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);
    import arm_pkg::*;

    logic               r_vld1, r_vld2;
    logic [1:0]         r_kind1, r_kind2;
    logic signed [32:0] r_c, r_s;
    logic signed [15:0] r_cos, r_sin;

    logic signed [32:0] n_c, n_s, xe, ye;

    function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
        logic signed [33:0] t;
        t = ($signed({v[32], v}) + 34'sd32768) >>> 16;
        if (t > 34'(ONE_Q14)) begin
            return 16'(ONE_Q14);
        end else if (t < -34'(ONE_Q14)) begin
            return -16'(ONE_Q14);
        end
        return t[15:0];
    endfunction

    always_comb begin
        xe = {i_st.x[31], i_st.x};
        ye = {i_st.y[31], i_st.y};
        unique case (i_st.quad)
            2'd0: begin
                n_c = xe;
                n_s = ye;
            end
            2'd1: begin
                n_c = -ye;
                n_s = xe;
            end
            2'd2: begin
                n_c = -xe;
                n_s = -ye;
            end
            default: begin
                n_c = ye;
                n_s = -xe;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1  <= i_st.vld;
            r_kind1 <= i_st.kind;
            r_c     <= n_c;
            r_s     <= n_s;
            r_vld2  <= r_vld1;
            r_kind2 <= r_kind1;
            r_cos   <= to_q14(r_c);
            r_sin   <= to_q14(r_s);
        end
    end

    assign o_vld  = r_vld2;
    assign o_kind = r_kind2;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

FILE: hw/rtl/axis_rotation_matrix.sv
// top level: elementary 3x3 rotation matrix about the x, y or z axis
// Takes one word per cycle unless the master side stalls, and gives one 3x3 matrix per
// word, in order. Three stages turn the angle into a phase of one turn (multiply,
// round, quadrant reduction), one register stage per cordic step follows, two stages
// unfold the quadrant and round to q1.14, and the output register holds the matrix.
// The whole pipeline advances together whenever the output register is empty or
// being taken, so a stall on the master side holds every stage in place.
// Entries are signed q1.14 with 1.0 = 16384; an axis selector of 3 gives the identity.
module axis_rotation_matrix #(
    parameter int CORDIC_ITERATIONS = arm_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [15:0]  i_s_axis_tdata,   // [15:0] angle
    input  logic [2:0]   i_s_axis_tuser,   // [1:0] kind, [2] angle_is_radians
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [143:0] o_m_axis_tdata    // m_row0_col0 .. m_row2_col2, 16 bits each
);
    import arm_pkg::*;

    localparam int NSTEP = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;

    logic               en;
    t_cord              w_st [NSTEP+1];
    logic               w_post_vld;
    logic [1:0]         w_post_kind;
    logic signed [15:0] w_cos, w_sin;

    logic               r_out_vld;
    logic signed [15:0] r_m [9];
    logic signed [15:0] n_m [9];

    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    arm_phase u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (i_s_axis_tvalid),
        .i_kind    (i_s_axis_tuser[1:0]),
        .i_angle   ($signed(i_s_axis_tdata)),
        .i_radians (i_s_axis_tuser[2]),
        .o_st      (w_st[0])
    );

    for (genvar g = 0; g < NSTEP; g++) begin : g_step
        arm_cordic_stage #(
            .IDX (g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_st    (w_st[g]),
            .o_st    (w_st[g+1])
        );
    end

    arm_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_st    (w_st[NSTEP]),
        .o_vld   (w_post_vld),
        .o_kind  (w_post_kind),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // place c and s by axis, identity elsewhere
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_m[k] = 16'sd0;
        end
        n_m[0] = 16'(ONE_Q14);
        n_m[4] = 16'(ONE_Q14);
        n_m[8] = 16'(ONE_Q14);
        unique case (w_post_kind)
            KIND_X: begin
                n_m[4] = w_cos;
                n_m[5] = w_sin;
                n_m[7] = -w_sin;
                n_m[8] = w_cos;
            end
            KIND_Y: begin
                n_m[0] = w_cos;
                n_m[2] = -w_sin;
                n_m[6] = w_sin;
                n_m[8] = w_cos;
            end
            KIND_Z: begin
                n_m[0] = w_cos;
                n_m[1] = w_sin;
                n_m[3] = -w_sin;
                n_m[4] = w_cos;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= w_post_vld;
            r_m       <= n_m;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_m[8], r_m[7], r_m[6], r_m[5], r_m[4],
                              r_m[3], r_m[2], r_m[1], r_m[0]};

    // a stall freezes the pipeline
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && w_post_vld) |=> (w_post_vld && $stable(w_cos) && $stable(w_sin)
                                 && $stable(w_post_kind)))
        else $error("pipeline moved during stall");

    // at least one axis is left untouched
    a_unit_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_m[0] == 16'sd16384 || r_m[4] == 16'sd16384
                       || r_m[8] == 16'sd16384))
        else $error("no unit axis in matrix");

    // off-diagonal entries are antisymmetric
    a_antisym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_m[1] == -r_m[3] && r_m[2] == -r_m[6] && r_m[5] == -r_m[7]))
        else $error("off-diagonal entries not antisymmetric");

endmodule
